// File: design/sliding_window_sender_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window sender
// Concurrent checks on the rising clock edge, switched off as a group when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_MACROS_SVH
`define SLIDING_WINDOW_SENDER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define SWS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SWS_ASSERT_IMP(lbl, ante, cons, msg)
`define SWS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/sws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window sender package
// Shared constants, codes and the interface types between the sequencer and
// the ack mark store.
// ----------------------------------------------------------------------------
package sws_pkg;

   // Transfer limits.
   localparam int MAX_PACKETS = 1024;
   localparam int MAX_WINDOW  = 32;

   // Field widths.
   localparam int PKT_W  = 11;
   localparam int WIN_W  = 6;
   localparam int OP_W   = 2;
   localparam int ACT_W  = 2;

   // Ack mark store: one entry per packet number, zero included.
   localparam int MARK_DEPTH = MAX_PACKETS + 1;
   localparam int ADDR_W     = $clog2(MARK_DEPTH);
   localparam int EPOCH_W    = 4;

   // Configuration registers.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = PKT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'b1;
   localparam logic [PKT_W-1:0] TOTAL_RESET  = 11'd1;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd5;

   // Event codes.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

   // Result actions.
   localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RETX = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FIN  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_IGN  = 2'd3;

   // Requests from the sequencer to the mark store.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic              new_epoch;
      logic [ADDR_W-1:0] addr;
   } mark_req_type;

   // Status from the mark store.
   typedef struct packed {
      logic ready;
      logic hit;
   } mark_sts_type;

endpackage

// File: design/sws_mark_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ack mark store
// One entry per packet number holding the epoch in which that ack was seen.
// An entry is marked when it holds the current epoch, so a new transfer
// clears every mark by moving to the next epoch. When the epoch wraps, and
// after reset, a clearing pass writes zero to every entry, one a cycle.
// ----------------------------------------------------------------------------
module sws_mark_store (
   input  logic                  clock,
   input  logic                  reset,
   input  sws_pkg::mark_req_type mark_req,
   output sws_pkg::mark_sts_type mark_sts
);

   logic [sws_pkg::EPOCH_W-1:0] mem [0:sws_pkg::MARK_DEPTH-1];
   logic [sws_pkg::EPOCH_W-1:0] rd_data_ff;

   logic                        clearing_ff, clearing_in;
   logic [sws_pkg::ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [sws_pkg::EPOCH_W-1:0] epoch_ff, epoch_in;

   logic                        wr_en;
   logic [sws_pkg::ADDR_W-1:0]  wr_addr;
   logic [sws_pkg::EPOCH_W-1:0] wr_data;

   // The clearing pass owns the write port while it runs.
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = mark_req.wr_en;
         wr_addr = mark_req.addr;
         wr_data = epoch_ff;
      end
   end

   // Memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mark_req.rd_en) begin
         rd_data_ff <= mem[mark_req.addr];
      end
   end

   // Epoch advance and clearing pass control.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      epoch_in    = epoch_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == sws_pkg::ADDR_W'(sws_pkg::MARK_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + sws_pkg::ADDR_W'(1);
         end
      end else if (mark_req.new_epoch) begin
         if (epoch_ff == '1) begin
            clearing_in = 1'b1;
            clr_addr_in = '0;
            epoch_in    = sws_pkg::EPOCH_W'(1);
         end else begin
            epoch_in = epoch_ff + sws_pkg::EPOCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         epoch_ff    <= sws_pkg::EPOCH_W'(1);
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         epoch_ff    <= epoch_in;
      end
   end

   assign mark_sts.ready = !clearing_ff;
   assign mark_sts.hit   = (rd_data_ff == epoch_ff);

endmodule

// File: design/sws_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window sender sequencer
// Takes one event at a time, keeps the window state, reads and updates the
// ack mark store, and emits the result beats through an output register.
// ----------------------------------------------------------------------------
`include "sliding_window_sender_macros.svh"

module sws_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sws_pkg::OP_W-1:0]    req_opcode,
   input  logic [sws_pkg::PKT_W-1:0]   req_ack_number,
   input  logic [sws_pkg::PKT_W-1:0]   eff_total,
   input  logic [sws_pkg::WIN_W-1:0]   eff_window,
   output sws_pkg::mark_req_type       mark_req,
   input  sws_pkg::mark_sts_type       mark_sts,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sws_pkg::ACT_W-1:0]   rsp_action,
   output logic [sws_pkg::PKT_W-1:0]   rsp_packet_number,
   output logic                        rsp_last
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_PREP = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic                      active_ff, active_in;
   logic [sws_pkg::PKT_W-1:0] ha_ff, ha_in;
   logic [sws_pkg::PKT_W-1:0] hs_ff, hs_in;
   logic [sws_pkg::PKT_W-1:0] ack_ff, ack_in;
   logic                      retx_pend_ff, retx_pend_in;
   logic [sws_pkg::PKT_W-1:0] retx_pkt_ff, retx_pkt_in;
   logic                      fin_pend_ff, fin_pend_in;
   logic                      fill_pend_ff, fill_pend_in;
   logic [sws_pkg::PKT_W-1:0] cur_ff, cur_in;
   logic [sws_pkg::PKT_W-1:0] end_ff, end_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [sws_pkg::ACT_W-1:0] rsp_action_ff, rsp_action_in;
   logic [sws_pkg::PKT_W-1:0] rsp_pkt_ff, rsp_pkt_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      can_emit;
   logic                      beat_load;
   logic [sws_pkg::ACT_W-1:0] beat_action;
   logic [sws_pkg::PKT_W-1:0] beat_pkt;
   logic                      beat_last;

   logic [sws_pkg::PKT_W:0]   win_sum;
   logic [sws_pkg::PKT_W-1:0] win_end;
   logic [sws_pkg::PKT_W-1:0] win_lo;

   // Handshake: one event at a time, and none while the store is clearing.
   assign req_stall = !((state_ff == S_IDLE) && mark_sts.ready);
   assign accept    = req_valid && !req_stall;
   assign can_emit  = !rsp_valid_ff || !rsp_stall;

   // Window bounds: the end is capped at the total, the start is past both
   // the highest ack and the highest packet sent.
   assign win_sum = {1'b0, ha_ff} + (sws_pkg::PKT_W + 1)'(eff_window);
   assign win_end = (win_sum > {1'b0, eff_total}) ? eff_total
                                                  : win_sum[sws_pkg::PKT_W-1:0];
   assign win_lo  = (hs_ff > ha_ff) ? hs_ff : ha_ff;

   // Event sequencing.
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      ha_in        = ha_ff;
      hs_in        = hs_ff;
      ack_in       = ack_ff;
      retx_pend_in = retx_pend_ff;
      retx_pkt_in  = retx_pkt_ff;
      fin_pend_in  = fin_pend_ff;
      fill_pend_in = fill_pend_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      mark_req     = '0;
      beat_load    = 1'b0;
      beat_action  = sws_pkg::ACT_IGN;
      beat_pkt     = '0;
      beat_last    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ack_in   = req_ack_number;
               state_in = S_EMIT;
               if (req_opcode == sws_pkg::OP_START) begin
                  // New transfer: fresh marks, empty window.
                  mark_req.new_epoch = 1'b1;
                  ha_in     = '0;
                  hs_in     = '0;
                  active_in = 1'b1;
                  if (eff_total == '0) begin
                     fin_pend_in = 1'b1;
                     active_in   = 1'b0;
                  end else begin
                     state_in = S_PREP;
                  end
               end else if ((req_opcode inside {sws_pkg::OP_ACK, sws_pkg::OP_TICK})
                            && active_ff) begin
                  if (ha_ff >= eff_total) begin
                     fin_pend_in = 1'b1;
                     active_in   = 1'b0;
                  end else if (req_opcode == sws_pkg::OP_TICK) begin
                     retx_pend_in = 1'b1;
                     retx_pkt_in  = ha_ff + sws_pkg::PKT_W'(1);
                  end else if (req_ack_number <= eff_total) begin
                     mark_req.rd_en = 1'b1;
                     mark_req.addr  = req_ack_number;
                     state_in       = S_EVAL;
                  end
               end
            end
         end

         S_EVAL: begin
            // A repeated ack asks for the packet after it.
            retx_pend_in = mark_sts.hit && (ack_ff < eff_total);
            retx_pkt_in  = ack_ff + sws_pkg::PKT_W'(1);
            if (!mark_sts.hit) begin
               mark_req.wr_en = 1'b1;
               mark_req.addr  = ack_ff;
            end
            state_in = S_EMIT;
            if (ack_ff > ha_ff) begin
               ha_in = ack_ff;
               if (ack_ff >= eff_total) begin
                  fin_pend_in = 1'b1;
                  active_in   = 1'b0;
               end else begin
                  state_in = S_PREP;
               end
            end
         end

         S_PREP: begin
            fill_pend_in = (win_end > win_lo);
            cur_in       = win_lo + sws_pkg::PKT_W'(1);
            end_in       = win_end;
            if (win_end > hs_ff) begin
               hs_in = win_end;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (can_emit) begin
               beat_load = 1'b1;
               if (retx_pend_ff) begin
                  beat_action  = sws_pkg::ACT_RETX;
                  beat_pkt     = retx_pkt_ff;
                  beat_last    = !(fin_pend_ff || fill_pend_ff);
                  retx_pend_in = 1'b0;
               end else if (fin_pend_ff) begin
                  beat_action = sws_pkg::ACT_FIN;
                  beat_last   = 1'b1;
                  fin_pend_in = 1'b0;
               end else if (fill_pend_ff) begin
                  beat_action = sws_pkg::ACT_SEND;
                  beat_pkt    = cur_ff;
                  beat_last   = (cur_ff == end_ff);
                  cur_in      = cur_ff + sws_pkg::PKT_W'(1);
                  if (cur_ff == end_ff) begin
                     fill_pend_in = 1'b0;
                  end
               end else begin
                  // Nothing came of this event.
                  beat_action = sws_pkg::ACT_IGN;
                  beat_last   = 1'b1;
               end
               if (beat_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds a beat while the receiver stalls.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_action_in = rsp_action_ff;
      rsp_pkt_in    = rsp_pkt_ff;
      rsp_last_in   = rsp_last_ff;
      if (beat_load) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = beat_action;
         rsp_pkt_in    = beat_pkt;
         rsp_last_in   = beat_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         ha_ff        <= '0;
         hs_ff        <= '0;
         retx_pend_ff <= 1'b0;
         fin_pend_ff  <= 1'b0;
         fill_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         ha_ff        <= ha_in;
         hs_ff        <= hs_in;
         retx_pend_ff <= retx_pend_in;
         fin_pend_ff  <= fin_pend_in;
         fill_pend_ff <= fill_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff        <= ack_in;
      retx_pkt_ff   <= retx_pkt_in;
      cur_ff        <= cur_in;
      end_ff        <= end_in;
      rsp_action_ff <= rsp_action_in;
      rsp_pkt_ff    <= rsp_pkt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_packet_number = rsp_pkt_ff;
   assign rsp_last          = rsp_last_ff;

   // Checks on the sequencing.
   `SWS_ASSERT_IMP(a_fill_bound, (state_ff == S_EMIT) && fill_pend_ff, cur_ff <= end_ff, "fill cursor past window end")
   `SWS_ASSERT_NXT(a_more_beats, beat_load && !beat_last, state_ff == S_EMIT, "event ended without a last beat")
   `SWS_ASSERT_IMP(a_idle_clean, state_ff == S_IDLE, !retx_pend_ff && !fin_pend_ff && !fill_pend_ff, "work left pending in idle")

endmodule

// File: design/sliding_window_sender.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window sender
// Sender side of a windowed retransmission scheme with fast retransmit.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the req_ channel (start, cumulative ack, timeout tick) and
// each gives one or more beats on the rsp_ channel: send, retransmit, FIN or
// ignored, with rsp_last set on the final beat of the event. Both channels
// use valid and stall; a beat moves when valid is high and stall is low.
// The csr_ port writes the packet total and the window size; write it only
// while no event is in progress.
// An event settled at once (timeout, FIN, ignored) goes from acceptance to
// the emit state; a start that sends packets passes the window preparation
// state first, an ack that reads the mark store without refilling the
// window the evaluation state, and an ack that refills the window
// evaluation and then preparation. Further beats follow one a cycle while
// the receiver does not stall, up to a whole window. The sequencer returns
// to idle as the last beat is loaded and takes the next event there once
// the mark store is ready. After reset the ack mark store runs a clearing
// pass with req_stall high; the same pass runs on every fifteenth start
// event, when the mark epoch wraps. A stalled receiver holds the current
// beat in the output register and pauses the event until it is taken.
// ----------------------------------------------------------------------------
module sliding_window_sender (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sws_pkg::OP_W-1:0]        req_opcode,
   input  logic [sws_pkg::PKT_W-1:0]       req_ack_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sws_pkg::ACT_W-1:0]       rsp_action,
   output logic [sws_pkg::PKT_W-1:0]       rsp_packet_number,
   output logic                            rsp_last,
   input  logic                            csr_wr_en,
   input  logic [sws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sws_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [sws_pkg::PKT_W-1:0] total_ff;
   logic [sws_pkg::WIN_W-1:0] window_ff;
   logic [sws_pkg::PKT_W-1:0] eff_total;
   logic [sws_pkg::WIN_W-1:0] eff_window;

   sws_pkg::mark_req_type mark_req;
   sws_pkg::mark_sts_type mark_sts;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= sws_pkg::TOTAL_RESET;
         window_ff <= sws_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sws_pkg::CSR_TOTAL: begin
               total_ff <= csr_wdata;
            end
            sws_pkg::CSR_WINDOW: begin
               window_ff <= csr_wdata[sws_pkg::WIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Register values brought into their working range.
   assign eff_total = (total_ff > sws_pkg::PKT_W'(sws_pkg::MAX_PACKETS))
                      ? sws_pkg::PKT_W'(sws_pkg::MAX_PACKETS) : total_ff;

   always_comb begin
      if (window_ff == '0) begin
         eff_window = sws_pkg::WIN_W'(1);
      end else if (window_ff > sws_pkg::WIN_W'(sws_pkg::MAX_WINDOW)) begin
         eff_window = sws_pkg::WIN_W'(sws_pkg::MAX_WINDOW);
      end else begin
         eff_window = window_ff;
      end
   end

   sws_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_ack_number    (req_ack_number),
      .eff_total         (eff_total),
      .eff_window        (eff_window),
      .mark_req          (mark_req),
      .mark_sts          (mark_sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_packet_number (rsp_packet_number),
      .rsp_last          (rsp_last)
   );

   sws_mark_store u_mark_store (
      .clock    (clock),
      .reset    (reset),
      .mark_req (mark_req),
      .mark_sts (mark_sts)
   );

endmodule
